>>> rtl/cie_pkg.sv
// Package for the CBOR item encoder: command codes, CBOR byte constants
// and the decoded-head record passed from the encode stage to the serializer.
// No dependencies.
package cie_pkg;

  // Command codes on the action field
  localparam logic [3:0] ACT_UINT      = 4'd0;
  localparam logic [3:0] ACT_BSTR_HEAD = 4'd1;
  localparam logic [3:0] ACT_TSTR_HEAD = 4'd2;
  localparam logic [3:0] ACT_PAYLOAD   = 4'd3;
  localparam logic [3:0] ACT_NULL      = 4'd4;
  localparam logic [3:0] ACT_ARR_START = 4'd5;
  localparam logic [3:0] ACT_ARR_END   = 4'd6;
  localparam logic [3:0] ACT_MAP_START = 4'd7;
  localparam logic [3:0] ACT_MAP_END   = 4'd8;

  // CBOR major types
  localparam logic [2:0] MT_UINT = 3'd0;
  localparam logic [2:0] MT_BSTR = 3'd2;
  localparam logic [2:0] MT_TSTR = 3'd3;

  // Additional-info codes
  localparam logic [4:0] AI_MAX_DIRECT = 5'd23;
  localparam logic [4:0] AI_ARG8       = 5'd24;
  localparam logic [4:0] AI_ARG16      = 5'd25;
  localparam logic [4:0] AI_ARG32      = 5'd26;
  localparam logic [4:0] AI_ARG64      = 5'd27;

  // Fixed single-byte items
  localparam logic [7:0] BYTE_NULL      = 8'hF6;
  localparam logic [7:0] BYTE_ARR_START = 8'h9F;
  localparam logic [7:0] BYTE_MAP_START = 8'hBF;
  localparam logic [7:0] BYTE_BREAK     = 8'hFF;

  localparam int unsigned ARG_W    = 64;
  localparam int unsigned ARG_CNT_W = 4;   // holds 0 to 8 argument bytes

  // Decoded item: head byte, argument byte count, argument left-aligned
  typedef struct packed {
    logic [7:0]           head;
    logic [ARG_CNT_W-1:0] nbytes;
    logic [ARG_W-1:0]     arg;
  } dec_t;

endpackage

>>> rtl/cie_cmd_if.sv
// Command channel interface of the CBOR item encoder.
// Carries valid, ready and one encoding command. No dependencies.
interface cie_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [63:0] value;
  logic [7:0]  data_byte;

  modport source (output valid, action, value, data_byte, input ready);
  modport sink   (input valid, action, value, data_byte, output ready);
endinterface

>>> rtl/cie_byte_if.sv
// Byte channel interface of the CBOR item encoder.
// Carries valid, ready, one encoded byte and its last flag. No dependencies.
interface cie_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

>>> rtl/cie_encode.sv
// Encode stage: registers each defined command as a decoded head (byte, count, argument).
// Depends on cie_pkg and cie_cmd_if.
module cie_encode (
  input  logic          clk,
  input  logic          rst_n,
  cie_cmd_if.sink       in_ch,
  output logic          dec_valid,
  output cie_pkg::dec_t dec,
  input  logic          dec_ready
);

  logic          dec_valid_r, dec_valid_nxt;
  cie_pkg::dec_t dec_r, dec_nxt;
  logic          known;
  logic [2:0]    major;
  logic          accept;

  assign in_ch.ready = !dec_valid_r || dec_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Pick major type for head commands
  always_comb begin
    case (in_ch.action)
      cie_pkg::ACT_BSTR_HEAD: major = cie_pkg::MT_BSTR;
      cie_pkg::ACT_TSTR_HEAD: major = cie_pkg::MT_TSTR;
      default:                major = cie_pkg::MT_UINT;
    endcase
  end

  // Decode the command into head byte, argument size and aligned argument
  always_comb begin
    dec_nxt.head   = 8'h00;
    dec_nxt.nbytes = '0;
    dec_nxt.arg    = '0;
    known          = 1'b1;
    case (in_ch.action)
      cie_pkg::ACT_UINT, cie_pkg::ACT_BSTR_HEAD, cie_pkg::ACT_TSTR_HEAD: begin
        if (in_ch.value <= 64'(cie_pkg::AI_MAX_DIRECT)) begin
          dec_nxt.head = {major, in_ch.value[4:0]};
        end else if (in_ch.value[63:8] == '0) begin
          dec_nxt.head   = {major, cie_pkg::AI_ARG8};
          dec_nxt.nbytes = cie_pkg::ARG_CNT_W'(1);
          dec_nxt.arg    = {in_ch.value[7:0], 56'h0};
        end else if (in_ch.value[63:16] == '0) begin
          dec_nxt.head   = {major, cie_pkg::AI_ARG16};
          dec_nxt.nbytes = cie_pkg::ARG_CNT_W'(2);
          dec_nxt.arg    = {in_ch.value[15:0], 48'h0};
        end else if (in_ch.value[63:32] == '0) begin
          dec_nxt.head   = {major, cie_pkg::AI_ARG32};
          dec_nxt.nbytes = cie_pkg::ARG_CNT_W'(4);
          dec_nxt.arg    = {in_ch.value[31:0], 32'h0};
        end else begin
          dec_nxt.head   = {major, cie_pkg::AI_ARG64};
          dec_nxt.nbytes = cie_pkg::ARG_CNT_W'(8);
          dec_nxt.arg    = in_ch.value;
        end
      end
      cie_pkg::ACT_PAYLOAD:   dec_nxt.head = in_ch.data_byte;
      cie_pkg::ACT_NULL:      dec_nxt.head = cie_pkg::BYTE_NULL;
      cie_pkg::ACT_ARR_START: dec_nxt.head = cie_pkg::BYTE_ARR_START;
      cie_pkg::ACT_MAP_START: dec_nxt.head = cie_pkg::BYTE_MAP_START;
      cie_pkg::ACT_ARR_END, cie_pkg::ACT_MAP_END: dec_nxt.head = cie_pkg::BYTE_BREAK;
      default:                known = 1'b0;
    endcase
  end

  // Hold the stage until the serializer takes it; drop undefined commands
  always_comb begin
    dec_valid_nxt = dec_valid_r;
    if (accept) begin
      dec_valid_nxt = known;
    end else if (dec_ready) begin
      dec_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else begin
      dec_valid_r <= dec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = dec_valid_r;
  assign dec       = dec_r;

endmodule

>>> rtl/cie_serialize.sv
// Serializer: emits the head byte, then argument bytes MSB first, one per cycle while out_ch.ready allows.
// Depends on cie_pkg and cie_byte_if.
module cie_serialize (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          dec_valid,
  input  cie_pkg::dec_t dec,
  output logic          dec_ready,
  cie_byte_if.source    out_ch
);

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [cie_pkg::ARG_CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [cie_pkg::ARG_W-1:0]     pend_arg_r, pend_arg_nxt;
  logic                          slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign dec_ready = slot_free && (pend_cnt_r == '0);

  // Advance: pending argument bytes first, then the next decoded head
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_arg_nxt  = pend_arg_r;
    if (slot_free) begin
      if (pend_cnt_r != '0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_arg_r[cie_pkg::ARG_W-1 -: 8];
        out_last_nxt  = (pend_cnt_r == cie_pkg::ARG_CNT_W'(1));
        pend_cnt_nxt  = pend_cnt_r - cie_pkg::ARG_CNT_W'(1);
        pend_arg_nxt  = {pend_arg_r[cie_pkg::ARG_W-9:0], 8'h00};
      end else if (dec_valid) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = dec.head;
        out_last_nxt  = (dec.nbytes == '0);
        pend_cnt_nxt  = dec.nbytes;
        pend_arg_nxt  = dec.arg;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_cnt_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    pend_arg_r <= pend_arg_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

endmodule

>>> rtl/cbor_item_encoder.sv
// CBOR item encoder top level: encode stage followed by the byte serializer.
// Depends on cie_pkg, cie_cmd_if, cie_byte_if, cie_encode and cie_serialize.
//
// Usage:
//   in_ch takes one command per item (action, value, data_byte) under
//   valid/ready. out_ch delivers the encoded CBOR bytes one at a time, with
//   last_byte set on the final byte of each command.
//   A command produces 1 byte (short head, payload byte, null, array or map
//   start, break) or 1 + 1/2/4/8 bytes (head with argument, MSB first).
//   Undefined action codes are accepted and produce nothing.
// Path: an accepted command is registered in the encode stage, then its first
//   byte is loaded into the serializer's output register and appears on out_ch,
//   where it is taken when the output side is free.
// Throughput: one output byte per cycle while out_ch.ready is high, set by the
//   single output register; single-byte commands stream at one per cycle, and a
//   head with n argument bytes holds the output until its last byte is sent.
// Reset (rst_n low, synchronous): both stages empty, out_ch.valid low.
// Stall: when out_ch.ready is low the current byte holds; one decoded command
//   waits in the encode stage and in_ch.ready drops once that stage is full.
module cbor_item_encoder (
  input  logic       clk,
  input  logic       rst_n,
  cie_cmd_if.sink    in_ch,
  cie_byte_if.source out_ch
);

  logic          dec_valid;
  logic          dec_ready;
  cie_pkg::dec_t dec;

  cie_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dec_valid (dec_valid),
    .dec       (dec),
    .dec_ready (dec_ready)
  );

  cie_serialize u_serialize (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec       (dec),
    .dec_ready (dec_ready),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/cie_checker.sv
// Port-level checks for the CBOR item encoder, bound to the top level.
// Depends on cbor_item_encoder port names only.
module cie_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // Stalled byte holds its value and flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("output byte changed under stall");

  // Argument bytes follow back to back once a non-final byte is taken
  a_arg_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_byte |=> out_valid)
    else $error("gap inside a multi-byte item");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind cbor_item_encoder cie_checker u_cie_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .last_byte (out_ch.last_byte)
);

>>> tb/cbor_item_encoder_test.sv
// Self-checking testbench for cbor_item_encoder: a directed table of commands
// followed by random command sequences, every encoded byte checked in order.
// Depends on cie_pkg, cie_cmd_if, cie_byte_if and the cbor_item_encoder RTL.
`timescale 1ns / 1ps

module cbor_item_encoder_test;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 230;
  localparam int QUIET_TAIL   = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int USE_MODEL    = -1;
  localparam int N_DIRECTED   = 24;

  // Action codes the block accepts but does not encode
  localparam logic [3:0] ACT_UNDEF_LO = 4'd9;
  localparam logic [3:0] ACT_UNDEF_HI = 4'd15;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } cbor_byte_t;

  // Directed command; gold holds n_gold bytes right-aligned, first byte on top
  typedef struct {
    logic [3:0]  act;
    logic [63:0] val;
    logic [7:0]  dat;
    int          n_gold;
    logic [71:0] gold;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cie_cmd_if  cmd ();
  cie_byte_if enc ();

  cbor_item_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd),
    .out_ch (enc)
  );

  cbor_byte_t expected_bytes[$];
  cbor_byte_t want_byte;
  int         errors = 0;
  int         cmds_sent = 0;
  int         undefined_sent = 0;
  int         defined_sent = 0;
  int         bytes_checked = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         idle_en = 1'b1;

  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{cie_pkg::ACT_UINT,      64'd0,                  8'h00, 1, 72'h00},
    '{cie_pkg::ACT_UINT,      64'd23,                 8'h00, 1, 72'h17},
    '{cie_pkg::ACT_UINT,      64'd24,                 8'h00, 2, 72'h1818},
    '{cie_pkg::ACT_UINT,      64'd255,                8'h00, 2, 72'h18FF},
    '{cie_pkg::ACT_UINT,      64'd256,                8'h00, 3, 72'h190100},
    '{cie_pkg::ACT_UINT,      64'hFFFF,               8'h00, 3, 72'h19FFFF},
    '{cie_pkg::ACT_UINT,      64'h1_0000,             8'h00, 5, 72'h1A00010000},
    '{cie_pkg::ACT_UINT,      64'hFFFF_FFFF,          8'h00, 5, 72'h1AFFFFFFFF},
    '{cie_pkg::ACT_UINT,      64'h1_0000_0000,        8'h00, 9,
      72'h1B_0000_0001_0000_0000},
    '{cie_pkg::ACT_UINT,      64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 9,
      72'h1B_FFFF_FFFF_FFFF_FFFF},
    '{cie_pkg::ACT_BSTR_HEAD, 64'd5,                  8'h00, 1, 72'h45},
    '{cie_pkg::ACT_PAYLOAD,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1, 72'h00},
    '{cie_pkg::ACT_PAYLOAD,   64'd0,                  8'hFF, 1, 72'hFF},
    '{cie_pkg::ACT_TSTR_HEAD, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 9,
      72'h7B_FFFF_FFFF_FFFF_FFFF},
    '{cie_pkg::ACT_TSTR_HEAD, 64'd24,                 8'h00, 2, 72'h7818},
    '{cie_pkg::ACT_BSTR_HEAD, 64'd23,                 8'h00, 1, 72'h57},
    '{cie_pkg::ACT_NULL,      64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1, 72'hF6},
    '{cie_pkg::ACT_ARR_START, 64'd0,                  8'h00, 1, 72'h9F},
    '{cie_pkg::ACT_ARR_END,   64'd0,                  8'h00, 1, 72'hFF},
    '{cie_pkg::ACT_MAP_START, 64'd0,                  8'h00, 1, 72'hBF},
    '{cie_pkg::ACT_MAP_END,   64'd0,                  8'h00, 1, 72'hFF},
    '{ACT_UNDEF_LO,           64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0, 72'h0},
    '{ACT_UNDEF_HI,           64'd24,                 8'h5A, 0, 72'h0},
    '{cie_pkg::ACT_BSTR_HEAD, 64'd1000,               8'hA5, USE_MODEL, 72'h0}
  };

  always #(CLK_HALF) clk = ~clk;

  function automatic void push_byte(logic [7:0] b, logic fin);
    cbor_byte_t e;
    e.data = b;
    e.last = fin;
    expected_bytes.push_back(e);
  endfunction

  // Shortest head: direct value up to 23, else 1/2/4/8 argument bytes MSB first
  function automatic void push_head(logic [2:0] major, logic [63:0] arg);
    int         n;
    logic [4:0] info;
    if (arg <= 64'(cie_pkg::AI_MAX_DIRECT)) begin
      push_byte({major, arg[4:0]}, 1'b1);
      return;
    end
    if (arg <= 64'hFF) begin
      info = cie_pkg::AI_ARG8;
      n = 1;
    end else if (arg <= 64'hFFFF) begin
      info = cie_pkg::AI_ARG16;
      n = 2;
    end else if (arg <= 64'hFFFF_FFFF) begin
      info = cie_pkg::AI_ARG32;
      n = 4;
    end else begin
      info = cie_pkg::AI_ARG64;
      n = 8;
    end
    push_byte({major, info}, 1'b0);
    for (int i = n; i > 0; i--) push_byte(arg[(i-1)*8 +: 8], i == 1);
  endfunction

  function automatic void predict_encoding(logic [3:0] act, logic [63:0] val,
                                           logic [7:0] dat);
    case (act)
      cie_pkg::ACT_UINT:      push_head(cie_pkg::MT_UINT, val);
      cie_pkg::ACT_BSTR_HEAD: push_head(cie_pkg::MT_BSTR, val);
      cie_pkg::ACT_TSTR_HEAD: push_head(cie_pkg::MT_TSTR, val);
      cie_pkg::ACT_PAYLOAD:   push_byte(dat, 1'b1);
      cie_pkg::ACT_NULL:      push_byte(cie_pkg::BYTE_NULL, 1'b1);
      cie_pkg::ACT_ARR_START: push_byte(cie_pkg::BYTE_ARR_START, 1'b1);
      cie_pkg::ACT_MAP_START: push_byte(cie_pkg::BYTE_MAP_START, 1'b1);
      cie_pkg::ACT_ARR_END, cie_pkg::ACT_MAP_END:
        push_byte(cie_pkg::BYTE_BREAK, 1'b1);
      default: ;
    endcase
  endfunction

  // Argument spread over every head size, with the size boundaries favored
  function automatic logic [63:0] random_arg();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 23));
      1: v = 64'($urandom_range(24, 255));
      2: v = 64'($urandom_range(256, 65535));
      3: begin
        v = {32'h0, $urandom};
        if (v < 64'h1_0000) v[16] = 1'b1;
      end
      4: begin
        v = {$urandom, $urandom};
        if (v[63:32] == 32'h0) v[32] = 1'b1;
      end
      default: begin
        case ($urandom_range(0, 8))
          0: v = 64'd23;
          1: v = 64'd24;
          2: v = 64'd255;
          3: v = 64'd256;
          4: v = 64'hFFFF;
          5: v = 64'h1_0000;
          6: v = 64'hFFFF_FFFF;
          7: v = 64'h1_0000_0000;
          default: v = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Offer one command, record its bytes once it is taken; n_gold < 0 predicts
  task automatic send_cmd(input logic [3:0] act, input logic [63:0] val,
                          input logic [7:0] dat, input int n_gold,
                          input logic [71:0] gold);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.action    <= act;
    cmd.value     <= val;
    cmd.data_byte <= dat;
    do @(negedge clk); while (cmd.ready !== 1'b1);
    if (n_gold < 0) predict_encoding(act, val, dat);
    else for (int i = 0; i < n_gold; i++)
      push_byte(gold[(n_gold-1-i)*8 +: 8], i == n_gold - 1);
    cmds_sent++;
    if (act > cie_pkg::ACT_MAP_END) undefined_sent++;
    else defined_sent++;
    @(posedge clk);
  endtask

  // Random payload-noise fields so ignored inputs toggle too
  task automatic send_random(input logic [3:0] act, input logic [63:0] val);
    send_cmd(act, val, 8'($urandom), USE_MODEL, 72'h0);
  endtask

  // Random output stalls while idle_en is set: ready stays low while stall_left counts down
  always @(posedge clk) begin
    if (stall_left > 0) begin
      enc.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      enc.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      enc.ready <= 1'b1;
    end
  end

  // Compare each byte taken at the coming edge with the oldest expectation
  always @(negedge clk) begin
    if (rst_n && enc.valid === 1'b1 && enc.ready === 1'b1) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %h last_byte %b", enc.out_byte, enc.last_byte);
        errors++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (enc.out_byte !== want_byte.data) begin
          $error("out_byte mismatch: expected %h, actual %h", want_byte.data, enc.out_byte);
          errors++;
        end
        if (enc.last_byte !== want_byte.last) begin
          $error("last_byte mismatch: expected %b, actual %b", want_byte.last,
                 enc.last_byte);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          len;
    int          cnt;
    logic [3:0]  act;
    logic [63:0] v;

    // Hold every command input at a known value from time zero
    cmd.valid     = 1'b0;
    cmd.action    = cie_pkg::ACT_UINT;
    cmd.value     = '0;
    cmd.data_byte = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: field extremes, every command, undefined codes
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].act, directed_rows[i].val, directed_rows[i].dat,
               directed_rows[i].n_gold, directed_rows[i].gold);
    send_cmd(cie_pkg::ACT_TSTR_HEAD, 64'h1234_5678, 8'h00, USE_MODEL, 72'h0);

    // Random part: mostly well-formed strings and containers, some noise
    defined_sent = 0;
    while (defined_sent < RANDOM_ITEMS) begin
      idle_en = (defined_sent < RANDOM_ITEMS - QUIET_TAIL) && ((defined_sent / 30) % 3 != 2);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_random(cie_pkg::ACT_UINT, random_arg());
      end else if (kind < 55) begin
        // String head followed by its payload
        act = ($urandom_range(0, 1) == 0) ? cie_pkg::ACT_BSTR_HEAD : cie_pkg::ACT_TSTR_HEAD;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 40) : $urandom_range(0, 10);
        send_random(act, 64'(len));
        repeat (len) send_random(cie_pkg::ACT_PAYLOAD, {$urandom, $urandom});
      end else if (kind < 70) begin
        // Indefinite array or map around a few scalars
        act = ($urandom_range(0, 1) == 0) ? cie_pkg::ACT_ARR_START : cie_pkg::ACT_MAP_START;
        send_random(act, {$urandom, $urandom});
        cnt = $urandom_range(0, 4);
        repeat (cnt) begin
          if ($urandom_range(0, 3) == 0) send_random(cie_pkg::ACT_NULL, {$urandom, $urandom});
          else send_random(cie_pkg::ACT_UINT, random_arg());
        end
        send_random((act == cie_pkg::ACT_ARR_START) ? cie_pkg::ACT_ARR_END :
                    cie_pkg::ACT_MAP_END, {$urandom, $urandom});
      end else if (kind < 78) begin
        send_random(cie_pkg::ACT_NULL, {$urandom, $urandom});
      end else if (kind < 86) begin
        // Stray payload byte or break outside any structure
        act = ($urandom_range(0, 2) == 0) ? cie_pkg::ACT_ARR_END :
              ($urandom_range(0, 1) == 0) ? cie_pkg::ACT_MAP_END : cie_pkg::ACT_PAYLOAD;
        send_random(act, {$urandom, $urandom});
      end else if (kind < 94) begin
        // Truncated string: head with an arbitrary length, short payload
        act = ($urandom_range(0, 1) == 0) ? cie_pkg::ACT_BSTR_HEAD : cie_pkg::ACT_TSTR_HEAD;
        send_random(act, random_arg());
        repeat ($urandom_range(0, 3)) send_random(cie_pkg::ACT_PAYLOAD, {$urandom, $urandom});
      end else begin
        v = {$urandom, $urandom};
        send_random(4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI)), v);
      end
    end

    // Drain: all expected bytes back, then a wait for stray output
    cmd.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands (%0d with undefined action codes)", cmds_sent,
             undefined_sent);
    $display("Checked %0d encoded bytes, %0d mismatches", bytes_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
